// ===== src/rn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rn_pkg
// Shared widths, word types and controller states for the rank normaliser.
// ----------------------------------------------------------------------------
package rn_pkg;

  localparam int MAX_LEN = 64;
  localparam int VAL_W   = 32;
  localparam int RANK_W  = 7;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [RANK_W-1:0]       rank_t;

  typedef struct packed {
    logic   valid;
    value_t key;
    rank_t  cnt;
  } token_t;

  typedef struct packed {
    logic  valid;
    rank_t rank;
  } unload_t;

  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_UNLOAD
  } state_t;

endpackage

// ===== src/rn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rn_if
// Valid/ready channels carrying list values in and ranks out.
// ----------------------------------------------------------------------------
interface rn_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  value;
  logic                final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface rn_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] rank;
  logic       final_rank;
  logic       dropped;

  modport source (output valid, output rank, output final_rank, output dropped,
                  input ready);
  modport sink   (input valid, input rank, input final_rank, input dropped,
                  output ready);
endinterface

// ===== src/rank_normalizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_normalizer_core
// Rank transform of a list through a chain of compare cells.
// ----------------------------------------------------------------------------
//  channel  dir  word                         handshake
//  values   in   value, final_item            valid/ready
//  ranks    out  rank, final_rank, dropped    valid/ready
//
// Values are taken one a cycle while loading; each walks the cell chain one
// cell a cycle until it reaches the first free cell. After the final word the
// block waits until the chain is empty, then shifts the ranks out of cell
// zero, one word per accepted output. No values are taken during the wait or
// the unload. Reset is synchronous and empties every cell.
// ----------------------------------------------------------------------------
module rank_normalizer_core
  import rn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rn_in_if.sink    values,
  rn_out_if.source ranks
);

  state_t state;
  state_t state_next;
  rank_t  fill;
  rank_t  fill_next;
  logic   ovf;
  logic   ovf_next;

  cell_ctrl_t            ctrl;
  token_t                tok_chain    [MAX_LEN+1];
  unload_t               unload_chain [MAX_LEN+1];
  logic [MAX_LEN-1:0]    busy;
  logic                  in_acc;
  logic                  out_acc;
  logic                  full;

  assign full    = fill == RANK_W'(MAX_LEN);
  assign in_acc  = values.valid & values.ready;
  assign out_acc = ranks.valid & ranks.ready;

  assign tok_chain[0].valid       = in_acc & ~full;
  assign tok_chain[0].key         = values.value;
  assign tok_chain[0].cnt         = '0;
  assign unload_chain[MAX_LEN]    = '0;

  genvar i;
  generate
    for (i = 0; i < MAX_LEN; i++) begin : g_cell
      rn_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .tok_in     (tok_chain[i]),
        .tok_out    (tok_chain[i+1]),
        .unload_in  (unload_chain[i+1]),
        .unload_out (unload_chain[i]),
        .busy       (busy[i])
      );
    end
  endgenerate

  assign ranks.rank       = unload_chain[0].rank;
  assign ranks.final_rank = fill == RANK_W'(1);
  assign ranks.dropped    = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      fill  <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      ovf   <= ovf_next;
    end
  end

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    ovf_next     = ovf;
    values.ready = 1'b0;
    ranks.valid  = 1'b0;
    ctrl.shift   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        values.ready = 1'b1;
        if (in_acc) begin
          if (full) begin
            ovf_next = 1'b1;
          end else begin
            fill_next = fill + RANK_W'(1);
          end
          if (values.final_item) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!(|busy)) begin
          state_next = ST_UNLOAD;
        end
      end
      ST_UNLOAD: begin
        ranks.valid = 1'b1;
        if (out_acc) begin
          ctrl.shift = 1'b1;
          fill_next  = fill - RANK_W'(1);
          if (fill == RANK_W'(1)) begin
            ovf_next   = 1'b0;
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  a_unload_chain_idle: assert property (@(posedge clk) disable iff (rst)
    ranks.valid |-> !(|busy))
    else $error("rank shown while a value is still in the chain");

  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(values.ready && ranks.valid))
    else $error("loading and unloading at once");

  a_unload_count: assert property (@(posedge clk) disable iff (rst)
    ranks.valid |-> (fill != '0) && unload_chain[0].valid)
    else $error("unloading an empty chain");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (ranks.valid && ranks.ready && ranks.final_rank) |=> values.ready && (fill == '0))
    else $error("no return to loading after the last rank");

endmodule

// ===== src/rn_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rn_cell
// One compare cell: holds a stored value and its running rank, counts a
// passing value against it and hands the value on to the next cell, or stores it when free.
// ----------------------------------------------------------------------------
module rn_cell
  import rn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  token_t     tok_in,
  output token_t     tok_out,
  input  unload_t    unload_in,
  output unload_t    unload_out,
  output logic       busy
);

  token_t tok;
  logic   occupied;
  value_t stored;
  rank_t  rank;
  logic   lt;
  logic   gt;

  assign lt = stored < tok.key;
  assign gt = tok.key < stored;

  assign tok_out.valid = tok.valid & occupied;
  assign tok_out.key   = tok.key;
  assign tok_out.cnt   = tok.cnt + RANK_W'(lt);

  assign unload_out.valid = occupied;
  assign unload_out.rank  = rank;
  assign busy             = tok.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
      occupied  <= 1'b0;
    end else begin
      tok <= tok_in;
      if (ctrl.shift) begin
        occupied <= unload_in.valid;
        rank     <= unload_in.rank;
      end else if (tok.valid) begin
        if (occupied) begin
          if (gt) begin
            rank <= rank + RANK_W'(1);
          end
        end else begin
          occupied <= 1'b1;
          stored   <= tok.key;
          rank     <= tok.cnt + RANK_W'(1);
        end
      end
    end
  end

endmodule
